/* design/rce_pkg.sv */
`default_nettype none

package rce_pkg;

  // Number of color channels per pixel and records a pixel can cause.
  localparam int CHANNELS = 4;
  localparam int NREC     = 2 * CHANNELS;
  localparam int REC_IW   = $clog2(NREC);

  // Queue between the classifier and the record sequencer.
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);

  localparam logic [6:0] MAX_RUN_RESET = 7'd127;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic [7:0] alpha_byte;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [6:0] run_length;
    logic [7:0] run_value;
    logic       last;
    logic       image_end;
  } rec_t;

  // One queued pixel: slots below CHANNELS end runs, slots from CHANNELS up flush them.
  typedef struct packed {
    logic [NREC-1:0]       mask;
    logic [NREC-1:0][6:0]  len;
    logic [NREC-1:0][7:0]  val;
  } job_t;

endpackage

`default_nettype wire

/* design/rce_front.sv */
`default_nettype none

module rce_front import rce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pix_t       in_data,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [6:0]                max_run_r;
  logic                      open_r, open_nxt;
  logic [CHANNELS-1:0][7:0]  byte_r, byte_nxt;
  logic [CHANNELS-1:0][6:0]  cnt_r, cnt_nxt;
  logic [3:0][7:0]           pix_bytes;
  logic                      accept;

  assign pix_bytes = {in_data.alpha_byte, in_data.blue_byte,
                      in_data.green_byte, in_data.red_byte};

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify each channel byte against its open run, then flush on an image's last pixel.
  always_comb begin
    q_job    = '0;
    byte_nxt = byte_r;
    cnt_nxt  = cnt_r;
    open_nxt = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!open_r) begin
        byte_nxt[c] = pix_bytes[c];
        cnt_nxt[c]  = 7'd1;
      end else if (pix_bytes[c] == byte_r[c] && cnt_r[c] < max_run_r) begin
        cnt_nxt[c] = 7'(cnt_r[c] + 7'd1);
      end else begin
        q_job.mask[c] = 1'b1;
        q_job.len[c]  = cnt_r[c];
        q_job.val[c]  = byte_r[c];
        byte_nxt[c]   = pix_bytes[c];
        cnt_nxt[c]    = 7'd1;
      end
    end
    if (in_data.last_pixel) begin
      for (int c = 0; c < CHANNELS; c++) begin
        q_job.mask[CHANNELS + c] = 1'b1;
        q_job.len[CHANNELS + c]  = cnt_nxt[c];
        q_job.val[CHANNELS + c]  = byte_nxt[c];
        byte_nxt[c] = '0;
        cnt_nxt[c]  = '0;
      end
      open_nxt = 1'b0;
    end
  end

  // Pixels that cause no record only update the run state.
  assign q_push = accept && (|q_job.mask);

  // Run state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_run_r <= MAX_RUN_RESET;
      open_r    <= 1'b0;
      byte_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        max_run_r <= cfg_wdata;
      end
      if (accept) begin
        open_r <= open_nxt;
        byte_r <= byte_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* design/rce_queue.sv */
`default_nettype none

module rce_queue import rce_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t               slot_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]     count_r, count_nxt;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = QCW'(count_r + QCW'(1));
    end else if (pop && !push) begin
      count_nxt = QCW'(count_r - QCW'(1));
    end
  end

  // Pointer and occupancy control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_r + QAW'(1));
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_r + QAW'(1));
      end
      count_r <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue occupancy above its depth");
`endif

endmodule

`default_nettype wire

/* design/rce_back.sv */
`default_nettype none

module rce_back import rce_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output rec_t      out_data
);

  logic              started_r;
  logic [NREC-1:0]   rem_r;
  logic              out_valid_r, out_valid_nxt;
  rec_t              out_data_r, rec_nxt;
  logic [NREC-1:0]   cur_mask, rem_nxt;
  logic [REC_IW-1:0] idx;
  logic              load;

  assign cur_mask = started_r ? rem_r : head_job.mask;
  assign load     = head_valid && (!out_valid_r || out_ready);

  // Pick the lowest pending record slot of the head job.
  always_comb begin
    idx = '0;
    for (int i = NREC - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        idx = REC_IW'(i);
      end
    end
    rem_nxt = cur_mask & ~(NREC'(1) << idx);
  end

  // Build the record for the chosen slot.
  always_comb begin
    rec_nxt.image_end  = (idx >= REC_IW'(CHANNELS));
    rec_nxt.channel    = rec_nxt.image_end ? 2'(idx - REC_IW'(CHANNELS)) : 2'(idx);
    rec_nxt.run_length = head_job.len[idx];
    rec_nxt.run_value  = head_job.val[idx];
    rec_nxt.last       = (rem_nxt == '0);
  end

  assign pop = load && (rem_nxt == '0);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        started_r <= (rem_nxt != '0);
        rem_r     <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.run_length != '0))
    else $error("record with zero run length");
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (load && rec_nxt.last) |=> !started_r)
    else $error("sequencer kept state after the last record of an item");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled record dropped or changed");
`endif

endmodule

`default_nettype wire

/* design/rgba_channel_rle_encoder_top.sv */
// The first record of a pixel passes through the job queue and then the sequencer's output register.
// A pixel causes 0 to 8 records; the record sequencer drives one record per cycle onto
// the output while the receiver does not stall it.
// A two-entry job queue lets pixels be classified while earlier records drain.
// Reset (synchronous, rst_n low): runs closed, queue empty, max_run back to 127.
`default_nettype none

module rgba_channel_rle_encoder_top import rce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pix_t       in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rec_t            out_data
);

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head;

  rce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  rce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  rce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_rgba_channel_rle_encoder_top.sv */
`timescale 1ns / 1ps

module tb_rgba_channel_rle_encoder_top;
  import rce_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = 7'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pix_t       in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rec_t       out_data;

  // Model of the encoder: one open run per channel plus the run limit.
  logic [7:0] run_val [CHANNELS];
  logic [6:0] run_cnt [CHANNELS];
  logic       runs_open;
  logic [6:0] run_limit;

  // Records the encoder still owes us, oldest first.
  rec_t run_records [$];

  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   errors = 0;
  int   pixels_sent = 0;
  int   records_seen = 0;
  int   images_sent = 0;
  int   cycle_count = 0;
  pix_t prev_pix = '0;

  rgba_channel_rle_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Work out the records one accepted pixel causes and queue them.
  task automatic encode_pixel(input pix_t p);
    logic [7:0] bytes [CHANNELS];
    rec_t       recs [NREC];
    int         n;
    n = 0;
    bytes[0] = p.red_byte;
    bytes[1] = p.green_byte;
    bytes[2] = p.blue_byte;
    bytes[3] = p.alpha_byte;
    // A differing byte or a run at its limit closes the run.
    for (int c = 0; c < CHANNELS; c++) begin
      if (!runs_open) begin
        run_val[c] = bytes[c];
        run_cnt[c] = 7'd1;
      end else if (bytes[c] == run_val[c] && run_cnt[c] < run_limit) begin
        run_cnt[c] = run_cnt[c] + 7'd1;
      end else begin
        recs[n] = '{channel: c[1:0], run_length: run_cnt[c], run_value: run_val[c],
                    last: 1'b0, image_end: 1'b0};
        n++;
        run_val[c] = bytes[c];
        run_cnt[c] = 7'd1;
      end
    end
    runs_open = 1'b1;
    // The final pixel of an image flushes every run.
    if (p.last_pixel) begin
      for (int c = 0; c < CHANNELS; c++) begin
        recs[n] = '{channel: c[1:0], run_length: run_cnt[c], run_value: run_val[c],
                    last: 1'b0, image_end: 1'b1};
        n++;
        run_val[c] = 8'd0;
        run_cnt[c] = 7'd0;
      end
      runs_open = 1'b0;
      images_sent++;
    end
    if (n > 0) recs[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) run_records.push_back(recs[k]);
  endtask

  // Offer one pixel, with a random gap first, and wait until it is taken.
  task automatic send_pixel(input pix_t p);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_pixel(p);
    prev_pix = p;
    pixels_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input logic lastp);
    pix_t p;
    p = '{red_byte: r, green_byte: g, blue_byte: b, alpha_byte: a, last_pixel: lastp};
    send_pixel(p);
  endtask

  // Stop sending, let every owed record drain, then idle for SETTLE_CYCLES.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (run_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_run(input logic [6:0] v);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    run_limit = v;
  endtask

  // A byte that repeats the previous one at the given chance, else random with the extremes now and then.
  function automatic logic [7:0] next_byte(input logic [7:0] prev, input int repeat_pct);
    int pick;
    if ($urandom_range(0, 99) < repeat_pct) return prev;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Compare each record that the receiver takes with the oldest owed one.
  always @(posedge clk) begin : record_check
    rec_t want;
    if (rst_n && out_valid && out_ready) begin
      records_seen++;
      if (run_records.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected record: ch=%0d len=%0d val=%02h last=%b end=%b",
                   out_data.channel, out_data.run_length, out_data.run_value,
                   out_data.last, out_data.image_end);
      end else begin
        want = run_records.pop_front();
        if (out_data.channel !== want.channel || out_data.run_length !== want.run_length ||
            out_data.run_value !== want.run_value || out_data.last !== want.last ||
            out_data.image_end !== want.image_end) begin
          errors++;
          if (errors <= 10) begin
            $display("record mismatch: want ch=%0d len=%0d val=%02h last=%b end=%b",
                     want.channel, want.run_length, want.run_value, want.last,
                     want.image_end);
            $display("                  got ch=%0d len=%0d val=%02h last=%b end=%b",
                     out_data.channel, out_data.run_length, out_data.run_value,
                     out_data.last, out_data.image_end);
          end
        end
      end
    end
  end

  // Single-pixel images at the byte extremes, plus a few short runs.
  task automatic test_extremes();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_bytes(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_bytes(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0);
    send_bytes(8'h5A, 8'h5A, 8'h3C, 8'h3C, 1'b1);
  endtask

  // A limit of zero acts as one, so every run closes after a single byte.
  task automatic test_zero_limit();
    write_max_run(7'd0);
    repeat (3) send_bytes(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
    send_bytes(8'h11, 8'h22, 8'h33, 8'h44, 1'b1);
  endtask

  // Lowering the limit mid-run closes the run with its longer count.
  task automatic test_limit_lowered();
    write_max_run(7'd127);
    repeat (6) send_bytes(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
    write_max_run(7'd2);
    send_bytes(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
    send_bytes(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
    send_bytes(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1);
    write_max_run(7'd1);
    send_bytes(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    send_bytes(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);
  endtask

  // Runs long enough to hit the full limit on some channels.
  task automatic test_saturated_runs();
    write_max_run(7'd127);
    snd_idle_pct  = 0;
    rcv_stall_pct = 33;
    for (int i = 0; i < 130; i++)
      send_bytes(8'h3C, 8'hC3, next_byte(prev_pix.blue_byte, 92),
                 8'($urandom_range(0, 255)), i == 129);
  endtask

  // Random images, mostly runs with random content, some pure noise.
  task automatic test_random_images(input int snd_pct, input int rcv_pct,
                                    input logic [6:0] limit, input int n_items);
    pix_t p;
    int   rep;
    write_max_run(limit);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int i = 0; i < n_items; i++) begin
      rep = ($urandom_range(0, 99) < 85) ? 75 : 0;
      p.red_byte   = next_byte(prev_pix.red_byte, rep);
      p.green_byte = next_byte(prev_pix.green_byte, rep);
      p.blue_byte  = next_byte(prev_pix.blue_byte, rep);
      p.alpha_byte = next_byte(prev_pix.alpha_byte, rep);
      p.last_pixel = ($urandom_range(0, 11) == 0);
      send_pixel(p);
    end
  endtask

  // Stop the run if it hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_rgba_channel_rle_encoder_top: done, errors");
    $finish;
  end

  initial begin : main
    for (int c = 0; c < CHANNELS; c++) begin
      run_val[c] = 8'd0;
      run_cnt[c] = 7'd0;
    end
    runs_open = 1'b0;
    run_limit = MAX_RUN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_zero_limit();
    test_limit_lowered();
    test_saturated_runs();
    test_random_images(0, 0, 7'($urandom_range(2, 12)), 77);
    test_random_images(71, 0, 7'd1, 77);
    test_random_images(0, 71, 7'($urandom_range(1, 127)), 77);
    test_random_images(33, 33, 7'($urandom_range(1, 6)), 77);

    settle_idle();
    if (run_records.size() != 0) begin
      errors++;
      $display("%0d records never arrived", run_records.size());
    end
    $display("sent %0d pixels in %0d images, checked %0d records", pixels_sent,
             images_sent, records_seen);
    $display("limits 0, 1, 2, 127 and random ones, under four idle and stall mixes");
    if (errors == 0) begin
      $display("tb_rgba_channel_rle_encoder_top: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_rgba_channel_rle_encoder_top: done, errors");
    end
    $finish;
  end

endmodule

/* rgba_channel_rle_encoder_top.f */
design/rce_pkg.sv
design/rce_front.sv
design/rce_queue.sv
design/rce_back.sv
design/rgba_channel_rle_encoder_top.sv
tb/sv/tb_rgba_channel_rle_encoder_top.sv
